// ===== hdl/nst_pkg.sv =====
// nst_pkg: shared types and constants of the node sequence tracker
// depends on nothing; used by node_sequence_tracker, nst_loss_check and node_sequence_tracker_tb
`timescale 1ns / 1ps

package nst_pkg;

    // default number of node slots
    localparam int NODES_DEF = 8;

    // timeout register value after reset, in ms
    localparam logic [31:0] TIMEOUT_RST = 32'd3000;

    // word kinds on the input channel
    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_SWEEP = 2'd2;

    // per slot record kept in the slot memory
    typedef struct packed {
        logic [31:0] prev_seq;
        logic [31:0] heard_at;
        logic [31:0] dup_count;
        logic [31:0] loss_count;
        logic [31:0] rx_count;
    } entry_t;

endpackage

// ===== hdl/node_sequence_tracker.sv =====
// node_sequence_tracker: per node sequence loss and duplicate tracker, top level
// depends on nst_pkg (entry_t, status and kind codes, reset constants)
//
//  channel  | signals                                     | direction | handshake
//  ---------+---------------------------------------------+-----------+-----------
//  input    | kind, node_id, seq, now_ms                  | in        | in_valid / in_ready
//  output   | status, slot, is_duplicate, lost_total,     | out       | out_valid / out_ready
//           | duplicate_total, received_total,            |           |
//           | all_received, live_nodes                    |           |
//  config   | cfg_wdata (timeout_ms)                      | in        | cfg_we, no wait
//
// a measurement word does id compare and slot memory read, then
// update and write back over the write port
// a tick word starts a sweep that reads one slot record per cycle unless a waiting result stalls it
// reset clears the slot valid bits at once; no clearing pass is needed
// a result waiting on out_ready stalls the next word's update or sweep step;
// in_ready stays low until that word is done
`timescale 1ns / 1ps

module node_sequence_tracker #(
    parameter int NODES = nst_pkg::NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  node_id,
    input  logic [31:0] seq,
    input  logic [31:0] now_ms,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [2:0]  slot,
    output logic        is_duplicate,
    output logic [31:0] lost_total,
    output logic [31:0] duplicate_total,
    output logic [31:0] received_total,
    output logic [31:0] all_received,
    output logic [3:0]  live_nodes,
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int SW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = $clog2(NODES + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(NODES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MEAS,
        S_SWEEP
    } state_t;

    state_t               state_reg;
    logic [NODES-1:0]     slot_used_reg;
    logic [NODES-1:0]     silent_reg;
    logic [7:0]           slot_node_reg [NODES];
    logic [31:0]          timeout_ms_reg;
    logic [31:0]          rx_all_reg;
    logic [LW-1:0]        live_reg;
    logic [LW-1:0]        live_next;

    // item held during processing
    logic [SW-1:0]        slot_reg;
    logic                 fresh_reg;
    logic                 reject_reg;
    logic [31:0]          seq_reg;
    logic [31:0]          now_reg;
    logic [7:0]           node_id_reg;

    // slot memory
    nst_pkg::entry_t      mem [NODES];
    nst_pkg::entry_t      rd_data_reg;
    logic [SW-1:0]        rd_addr;

    // output register
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [2:0]           slot_out_reg;
    logic                 dup_out_reg;
    logic [31:0]          lost_out_reg;
    logic [31:0]          dups_out_reg;
    logic [31:0]          rx_out_reg;
    logic [31:0]          all_out_reg;
    logic [3:0]           live_out_reg;

    logic                 out_free;
    logic                 hit_found;
    logic [SW-1:0]        hit_idx;
    logic                 free_found;
    logic [SW-1:0]        free_idx;
    logic                 accept;

    nst_pkg::entry_t      cur;
    nst_pkg::entry_t      upd;
    logic                 heard_before;
    logic                 dup_hit;
    logic                 gap_hit;
    logic [31:0]          silence;
    logic                 expire;
    logic                 meas_done;
    logic                 sweep_done;
    logic                 out_load;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // slot search: matching node first, else lowest free slot
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (!hit_found && slot_used_reg[i] && slot_node_reg[i] == node_id)
            begin
                hit_found = 1'b1;
                hit_idx   = SW'(i);
            end
            if (!free_found && !slot_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // memory read address
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = (kind == nst_pkg::KIND_TICK) ? '0
                             : (hit_found ? hit_idx : free_idx);
            S_MEAS:  rd_addr = slot_reg;
            S_SWEEP: rd_addr = (out_free && slot_reg != LAST_IDX) ? slot_reg + SW'(1)
                                                                    : slot_reg;
            default: rd_addr = '0;
        endcase
    end

    // measurement update of one slot record
    always_comb
    begin
        cur          = fresh_reg ? '0 : rd_data_reg;
        heard_before = (cur.rx_count != 32'd0);
        dup_hit      = heard_before && (seq_reg == cur.prev_seq);
        gap_hit      = heard_before && !dup_hit && (seq_reg > cur.prev_seq + 32'd1);
        upd          = cur;
        upd.prev_seq = seq_reg;
        upd.heard_at = now_reg;
        upd.rx_count = cur.rx_count + 32'd1;
        if (dup_hit)
            upd.dup_count = cur.dup_count + 32'd1;
        if (gap_hit)
            upd.loss_count = cur.loss_count + (seq_reg - cur.prev_seq - 32'd1);
    end

    // sweep test of the slot whose record was read
    assign silence = now_reg - rd_data_reg.heard_at;
    assign expire  = (state_reg == S_SWEEP) && slot_used_reg[slot_reg]
                     && !silent_reg[slot_reg] && (silence > timeout_ms_reg);

    assign meas_done  = (state_reg == S_MEAS) && out_free;
    assign sweep_done = (state_reg == S_SWEEP) && out_free && (slot_reg == LAST_IDX);
    assign out_load   = meas_done || sweep_done;

    // live count after this step
    always_comb
    begin
        live_next = live_reg;
        if (meas_done && !reject_reg && (fresh_reg || silent_reg[slot_reg]))
            live_next = live_reg + LW'(1);
        else if (expire)
            live_next = live_reg - LW'(1);
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (meas_done && !reject_reg)
            mem[slot_reg] <= upd;
        rd_data_reg <= mem[rd_addr];
    end

    // control, slot flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_used_reg  <= '0;
            silent_reg     <= '0;
            for (int i = 0; i < NODES; i++)
                slot_node_reg[i] <= '0;
            timeout_ms_reg <= nst_pkg::TIMEOUT_RST;
            rx_all_reg     <= '0;
            live_reg       <= '0;
            slot_reg       <= '0;
            fresh_reg      <= 1'b0;
            reject_reg     <= 1'b0;
            seq_reg        <= '0;
            now_reg        <= '0;
            node_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            slot_out_reg   <= '0;
            dup_out_reg    <= 1'b0;
            lost_out_reg   <= '0;
            dups_out_reg   <= '0;
            rx_out_reg     <= '0;
            all_out_reg    <= '0;
            live_out_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                timeout_ms_reg <= cfg_wdata;
            // result valid: set by a finished step, cleared once taken
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            live_reg <= live_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        seq_reg <= seq;
                        now_reg <= now_ms;
                        if (kind == nst_pkg::KIND_TICK)
                        begin
                            slot_reg  <= '0;
                            state_reg <= S_SWEEP;
                        end
                        else
                        begin
                            slot_reg    <= hit_found ? hit_idx : free_idx;
                            fresh_reg   <= !hit_found;
                            reject_reg  <= !hit_found && !free_found;
                            node_id_reg <= node_id;
                            state_reg   <= S_MEAS;
                        end
                    end
                end
                S_MEAS:
                begin
                    if (out_free)
                    begin
                        live_out_reg  <= 4'(live_next);
                        if (reject_reg)
                        begin
                            status_reg   <= nst_pkg::STATUS_FULL;
                            slot_out_reg <= '0;
                            dup_out_reg  <= 1'b0;
                            lost_out_reg <= '0;
                            dups_out_reg <= '0;
                            rx_out_reg   <= '0;
                            all_out_reg  <= rx_all_reg;
                        end
                        else
                        begin
                            slot_used_reg[slot_reg] <= 1'b1;
                            slot_node_reg[slot_reg] <= (fresh_reg) ? node_id_reg
                                                                   : slot_node_reg[slot_reg];
                            silent_reg[slot_reg]    <= 1'b0;
                            rx_all_reg              <= rx_all_reg + 32'd1;
                            status_reg   <= nst_pkg::STATUS_OK;
                            slot_out_reg <= 3'(slot_reg);
                            dup_out_reg  <= dup_hit;
                            lost_out_reg <= upd.loss_count;
                            dups_out_reg <= upd.dup_count;
                            rx_out_reg   <= upd.rx_count;
                            all_out_reg  <= rx_all_reg + 32'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SWEEP:
                begin
                    if (expire)
                        silent_reg[slot_reg] <= 1'b1;
                    if (sweep_done)
                    begin
                        status_reg    <= nst_pkg::STATUS_SWEEP;
                        slot_out_reg  <= '0;
                        dup_out_reg   <= 1'b0;
                        lost_out_reg  <= '0;
                        dups_out_reg  <= '0;
                        rx_out_reg    <= '0;
                        all_out_reg   <= rx_all_reg;
                        live_out_reg  <= 4'(live_next);
                        state_reg     <= S_IDLE;
                    end
                    else if (out_free)
                        slot_reg <= slot_reg + SW'(1);
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign slot            = slot_out_reg;
    assign is_duplicate    = dup_out_reg;
    assign lost_total      = lost_out_reg;
    assign duplicate_total = dups_out_reg;
    assign received_total  = rx_out_reg;
    assign all_received    = all_out_reg;
    assign live_nodes      = live_out_reg;

    // live counter tracks used slots that are not marked silent
    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_used_reg & ~silent_reg) == int'(live_reg))
        else $error("live counter out of step with slot flags");

    // a silent mark only sits on a used slot
    a_silent_used: assert property (@(posedge clk) disable iff (!rst_n)
        (silent_reg & ~slot_used_reg) == '0)
        else $error("silent mark on unused slot");

    // slots are claimed lowest first and never freed
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((slot_used_reg + NODES'(1)) & slot_used_reg) == '0)
        else $error("used slots do not form a prefix");

    // an accepted measurement leaves its slot claimed
    a_slot_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        meas_done && !reject_reg |=> slot_used_reg[$past(slot_reg)])
        else $error("measurement slot not claimed");

    // a full rejection only happens with every slot used
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        meas_done && reject_reg |-> (&slot_used_reg))
        else $error("rejected with a free slot");

endmodule

// ===== dv/nst_loss_check.sv =====
// nst_loss_check: watches the node sequence tracker channels, predicts every result
// word from its own slot table and compares it field by field
// depends on nst_pkg (kind and status codes, timeout reset value)
`timescale 1ns / 1ps

module nst_loss_check #(
    parameter int NODES = nst_pkg::NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  node_id,
    input  logic [31:0] seq,
    input  logic [31:0] now_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [2:0]  slot,
    input  logic        is_duplicate,
    input  logic [31:0] lost_total,
    input  logic [31:0] duplicate_total,
    input  logic [31:0] received_total,
    input  logic [31:0] all_received,
    input  logic [3:0]  live_nodes,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output int          mismatches,
    output int          reports_due
);

    // one predicted result word
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  slot;
        logic        dup;
        logic [31:0] lost_sum;
        logic [31:0] dup_sum;
        logic [31:0] rx_sum;
        logic [31:0] rx_grand;
        logic [3:0]  live;
    } report_t;

    // shadow slot table
    logic        used     [NODES];
    logic [7:0]  owner    [NODES];
    logic [31:0] tail_seq [NODES];
    logic [31:0] heard    [NODES];
    logic        silent   [NODES];
    logic [31:0] dups     [NODES];
    logic [31:0] lost     [NODES];
    logic [31:0] rx       [NODES];
    logic [31:0] rx_all;
    logic [31:0] timeout;

    report_t due_reports[$];
    int      fail_tally;

    // apply one input word to the shadow table and return its result word
    function automatic report_t track_word(logic k, logic [7:0] id, logic [31:0] s,
                                           logic [31:0] t);
        report_t     r;
        int          hit;
        int          live;
        logic [31:0] silence;
        logic [31:0] after_last;
        r = '0;
        hit = -1;
        live = 0;
        if (k == nst_pkg::KIND_TICK)
        begin
            // sweep: mark every used slot silent longer than the timeout
            for (int i = 0; i < NODES; i++)
            begin
                silence = t - heard[i];
                if (used[i] && silence > timeout)
                    silent[i] = 1'b1;
            end
            r.status = nst_pkg::STATUS_SWEEP;
        end
        else
        begin
            // node already in the table, else the lowest free slot
            for (int i = 0; i < NODES; i++)
                if (hit < 0 && used[i] && owner[i] == id)
                    hit = i;
            for (int i = 0; i < NODES; i++)
            begin
                if (hit < 0 && !used[i])
                begin
                    hit = i;
                    used[i] = 1'b1;
                    owner[i] = id;
                    tail_seq[i] = '0;
                    heard[i] = '0;
                    silent[i] = 1'b0;
                    dups[i] = '0;
                    lost[i] = '0;
                    rx[i] = '0;
                end
            end
            if (hit < 0)
            begin
                r.status = nst_pkg::STATUS_FULL;
            end
            else
            begin
                // duplicate or forward gap, only for a node heard before
                after_last = tail_seq[hit] + 32'd1;
                if (rx[hit] != 32'd0)
                begin
                    if (s == tail_seq[hit])
                    begin
                        dups[hit] = dups[hit] + 32'd1;
                        r.dup = 1'b1;
                    end
                    else if (s > after_last)
                    begin
                        lost[hit] = lost[hit] + (s - after_last);
                    end
                end
                tail_seq[hit] = s;
                heard[hit] = t;
                silent[hit] = 1'b0;
                rx[hit] = rx[hit] + 32'd1;
                rx_all = rx_all + 32'd1;
                r.status = nst_pkg::STATUS_OK;
                r.slot = hit[2:0];
                r.lost_sum = lost[hit];
                r.dup_sum = dups[hit];
                r.rx_sum = rx[hit];
            end
        end
        for (int i = 0; i < NODES; i++)
            if (used[i] && !silent[i])
                live++;
        r.rx_grand = rx_all;
        r.live = live[3:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_tally++;
        end
    endtask

    // track config, input and output words at every edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                used[i] = 1'b0;
                owner[i] = '0;
                tail_seq[i] = '0;
                heard[i] = '0;
                silent[i] = 1'b0;
                dups[i] = '0;
                lost[i] = '0;
                rx[i] = '0;
            end
            rx_all = '0;
            timeout = nst_pkg::TIMEOUT_RST;
            due_reports.delete();
            fail_tally = 0;
            mismatches <= 0;
            reports_due <= 0;
        end
        else
        begin
            if (cfg_we)
                timeout = cfg_wdata;
            if (in_valid && in_ready)
                due_reports.push_back(track_word(kind, node_id, seq, now_ms));
            if (out_valid && out_ready)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    fail_tally++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("status", want.status, status);
                    check_field("slot", want.slot, slot);
                    check_field("is_duplicate", want.dup, is_duplicate);
                    check_field("lost_total", want.lost_sum, lost_total);
                    check_field("duplicate_total", want.dup_sum, duplicate_total);
                    check_field("received_total", want.rx_sum, received_total);
                    check_field("all_received", want.rx_grand, all_received);
                    check_field("live_nodes", want.live, live_nodes);
                end
            end
            mismatches <= fail_tally;
            reports_due <= due_reports.size();
        end
    end

endmodule

// ===== dv/node_sequence_tracker_tb.sv =====
// node_sequence_tracker_tb: drives measurement and sweep words into the tracker,
// retunes the timeout between phases and gives the verdict
// depends on nst_pkg, node_sequence_tracker and nst_loss_check
`timescale 1ns / 1ps

module node_sequence_tracker_tb;

    localparam int NODES = nst_pkg::NODES_DEF;
    localparam int PHASES = 5;
    localparam int WORDS_PER_PHASE = 100;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    // long enough for a full sweep of all NODES slots, plus margin
    localparam int SETTLE_CYCLES = NODES + 4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [7:0]  node_id;
    logic [31:0] seq;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [2:0]  slot;
    logic        is_duplicate;
    logic [31:0] lost_total;
    logic [31:0] duplicate_total;
    logic [31:0] received_total;
    logic [31:0] all_received;
    logic [3:0]  live_nodes;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    int          mismatches;
    int          reports_due;
    int          stall_cycles;
    bit          hold_req;
    bit          hold_taken;
    bit          no_idle;
    logic [31:0] clock_ms;
    logic [7:0]  known_id [NODES];
    logic [31:0] sent_seq [NODES];
    logic [31:0] phase_timeout [PHASES];

    node_sequence_tracker uut (.*);

    nst_loss_check loss_check (.*);

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // offer one word and hold it until accepted, sometimes after a gap
    task automatic send_word(logic k, logic [7:0] id, logic [31:0] s, logic [31:0] t);
        if (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        node_id <= id;
        seq <= s;
        now_ms <= t;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (reports_due != 0);
    endtask

    // new timeout, only once the block is idle
    task automatic retune(logic [31:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        hold_taken = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= no_idle || ($urandom_range(99) >= 13);
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int          pick;
        int          k;
        logic [31:0] s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = nst_pkg::KIND_MEAS;
        node_id = '0;
        seq = '0;
        now_ms = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        known_id = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
        phase_timeout[0] = nst_pkg::TIMEOUT_RST;
        phase_timeout[1] = $urandom_range(200, 2000);
        phase_timeout[2] = 32'd0;
        phase_timeout[3] = $urandom;
        phase_timeout[4] = 32'hFFFF_FFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // node 0: first word, duplicate, in order, huge gap, step back
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'd0, 32'd0);
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'd0, 32'd10);
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'd1, 32'd20);
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'hFFFF_FFFF, 32'd30);
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'd5, 32'd40);
        // node 255: sequence wraps through zero, then a small gap
        send_word(nst_pkg::KIND_MEAS, 8'hFF, 32'hFFFF_FFFE, 32'd50);
        send_word(nst_pkg::KIND_MEAS, 8'hFF, 32'hFFFF_FFFF, 32'd60);
        send_word(nst_pkg::KIND_MEAS, 8'hFF, 32'd0, 32'd70);
        send_word(nst_pkg::KIND_MEAS, 8'hFF, 32'd3, 32'd80);
        // sweeps: exactly at the timeout, one past it, then a mark cleared
        send_word(nst_pkg::KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 32'd3040);
        send_word(nst_pkg::KIND_TICK, 8'h00, 32'd0, 32'd3041);
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'd6, 32'd3050);
        // time far ahead marks every node silent
        send_word(nst_pkg::KIND_TICK, 8'h00, 32'd0, 32'hFFFF_FFFF);

        // zero timeout: silent as soon as time moves on
        retune(32'd0);
        send_word(nst_pkg::KIND_MEAS, 8'hFF, 32'd4, 32'd100);
        send_word(nst_pkg::KIND_TICK, 8'h5A, 32'h1234_5678, 32'd100);
        send_word(nst_pkg::KIND_TICK, 8'hA5, 32'h8765_4321, 32'd101);

        // largest timeout: nothing can ever time out
        retune(32'hFFFF_FFFF);
        send_word(nst_pkg::KIND_MEAS, 8'h00, 32'd7, 32'd200);
        send_word(nst_pkg::KIND_TICK, 8'h00, 32'd0, 32'd199);
        sent_seq[0] = 32'd7;
        sent_seq[1] = 32'd4;

        // fill the table, then one node too many
        for (int i = 2; i < NODES; i++)
        begin
            sent_seq[i] = $urandom;
            send_word(nst_pkg::KIND_MEAS, known_id[i], sent_seq[i], 32'd300 + i);
        end
        send_word(nst_pkg::KIND_MEAS, 8'h40, $urandom, 32'd320);

        // random phases, one timeout each
        clock_ms = 32'd400;
        for (int p = 0; p < PHASES; p++)
        begin
            retune(phase_timeout[p]);
            no_idle = (p == 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (p == 1 && n == 30)
                    hold_req = 1'b1;
                if (p == 3 && n == 50)
                    drain();
                // time mostly creeps forward, sometimes jumps or wraps
                pick = $urandom_range(99);
                if (pick < 3)
                    clock_ms = $urandom;
                else if (pick < 8)
                    clock_ms = clock_ms + $urandom_range(2000, 9000);
                else
                    clock_ms = clock_ms + $urandom_range(0, 400);
                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    send_word(nst_pkg::KIND_TICK, 8'($urandom), $urandom, clock_ms);
                end
                else if (pick < 22)
                begin
                    send_word(nst_pkg::KIND_MEAS, 8'($urandom), $urandom, clock_ms);
                end
                else
                begin
                    // a tracked node, mostly in order
                    k = $urandom_range(NODES - 1);
                    pick = $urandom_range(99);
                    if (pick < 60)
                        s = sent_seq[k] + 32'd1;
                    else if (pick < 72)
                        s = sent_seq[k];
                    else if (pick < 84)
                        s = sent_seq[k] + $urandom_range(2, 50);
                    else if (pick < 92)
                        s = sent_seq[k] - $urandom_range(1, 20);
                    else if (pick < 96)
                        s = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    else
                        s = $urandom;
                    sent_seq[k] = s;
                    send_word(nst_pkg::KIND_MEAS, known_id[k], s, clock_ms);
                end
            end
        end

        // let the last words out, then the verdict
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/nst_pkg.sv
hdl/node_sequence_tracker.sv
dv/nst_loss_check.sv
dv/node_sequence_tracker_tb.sv
